[rtl/dsq_pkg.sv]
// Shared types and constants for the DMA receive segment queue.
// No dependencies; imported by dma_rx_segment_queue and its testbench.
package dsq_pkg;

    // Circular receive buffer size in bytes and descriptor ring depth
    localparam int BUFFER_BYTES = 1024;
    localparam int RING_DEPTH   = 8;

    localparam int START_W = $clog2(BUFFER_BYTES);      // byte index
    localparam int LEN_W   = $clog2(BUFFER_BYTES + 1);  // counts 0..BUFFER_BYTES
    localparam int PTR_W   = $clog2(RING_DEPTH);

    // Command codes
    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    typedef struct packed {
        logic             command;
        logic [LEN_W-1:0] remain_count;
    } t_in;

    typedef struct packed {
        logic               accepted;
        logic [START_W-1:0] segment_start;
        logic [LEN_W-1:0]   segment_length;
        logic               queue_empty;
    } t_out;

endpackage

[rtl/dma_rx_segment_queue.sv]
// Top level of the DMA receive segment queue: descriptor ring and result register.
// Depends on dsq_pkg.

// Tracks new-data segments of a circular DMA receive buffer. A push transaction
// (command CMD_PUSH) carries the DMA remaining count; the block turns it into a
// used count and, if that differs from the last one, stores a descriptor for the
// bytes between the previous and the current used count (wrapping past the end
// of the buffer). A remaining count above the buffer size is clamped. When the
// ring is full the oldest descriptor is overwritten. A pop transaction
// (command CMD_POP) returns the oldest descriptor's start and length. Each
// transaction yields exactly one result, which also reports whether the ring is
// empty afterwards. Throughput is one transaction per cycle unless a held result is
// stalled; the result appears in the cycle after acceptance, from the single result
// register after the update logic. Input stall follows output stall only while a
// result is held. Reset touches only the flags, pointers and used count.
module dma_rx_segment_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  dsq_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output dsq_pkg::t_out o_out_data
);
    import dsq_pkg::*;

    localparam logic [LEN_W-1:0] BUF_LEN  = LEN_W'(BUFFER_BYTES);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);

    function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
        return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
    endfunction

    // Descriptor storage; contents only read behind a set valid bit
    logic [START_W-1:0]  r_desc_start  [RING_DEPTH];
    logic [LEN_W-1:0]    r_desc_length [RING_DEPTH];
    logic [RING_DEPTH-1:0] r_valid, n_valid;
    logic [PTR_W-1:0]    r_rd_ptr, n_rd_ptr;
    logic [PTR_W-1:0]    r_wr_ptr, n_wr_ptr;
    logic [LEN_W-1:0]    r_prev_used, n_prev_used;

    // Result register
    logic r_out_valid;
    t_out r_out_data, n_out_data;

    logic               in_accept;
    logic               wr_en;
    logic [LEN_W-1:0]   remain_clamped;
    logic [LEN_W-1:0]   used;
    logic [LEN_W-1:0]   seg_len;
    logic [START_W-1:0] seg_start;

    // Result register drains or is taken this cycle -> room for a new transaction
    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_accept  = i_in_valid && !o_in_stall;

    // Segment arithmetic for a push
    always_comb begin
        remain_clamped = (i_in_data.remain_count > BUF_LEN) ? BUF_LEN
                                                            : i_in_data.remain_count;
        used = BUF_LEN - remain_clamped;
        if (r_prev_used < used) begin
            seg_len = used - r_prev_used;
        end else begin
            // wrapped past the end of the buffer
            seg_len = (BUF_LEN - r_prev_used) + used;
        end
        // previous used count equal to the buffer size starts at index 0
        seg_start = (r_prev_used == BUF_LEN) ? '0 : r_prev_used[START_W-1:0];
    end

    always_comb begin
        n_valid     = r_valid;
        n_rd_ptr    = r_rd_ptr;
        n_wr_ptr    = r_wr_ptr;
        n_prev_used = r_prev_used;
        wr_en       = 1'b0;
        n_out_data  = '0;
        if (in_accept) begin
            case (i_in_data.command)
                CMD_PUSH: begin
                    if (used != r_prev_used) begin
                        wr_en = 1'b1;
                        // overwrite of the oldest entry when full
                        if (r_valid[r_wr_ptr]) begin
                            n_rd_ptr = ptr_next(r_rd_ptr);
                        end
                        n_valid[r_wr_ptr]   = 1'b1;
                        n_wr_ptr            = ptr_next(r_wr_ptr);
                        n_prev_used         = used;
                        n_out_data.accepted = 1'b1;
                    end
                end
                CMD_POP: begin
                    if (r_valid[r_rd_ptr]) begin
                        n_out_data.accepted       = 1'b1;
                        n_out_data.segment_start  = r_desc_start[r_rd_ptr];
                        n_out_data.segment_length = r_desc_length[r_rd_ptr];
                        n_valid[r_rd_ptr]         = 1'b0;
                        n_rd_ptr                  = ptr_next(r_rd_ptr);
                    end
                end
                default: begin
                end
            endcase
        end
        n_out_data.queue_empty = !n_valid[n_rd_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_desc_start[r_wr_ptr]  <= seg_start;
            r_desc_length[r_wr_ptr] <= seg_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_rd_ptr    <= '0;
            r_wr_ptr    <= '0;
            r_prev_used <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_valid     <= n_valid;
            r_rd_ptr    <= n_rd_ptr;
            r_wr_ptr    <= n_wr_ptr;
            r_prev_used <= n_prev_used;
            if (in_accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Full ring: pointers meet
    a_full_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (&r_valid) |-> (r_rd_ptr == r_wr_ptr))
        else $error("full ring with read and write pointers apart");

    // Empty ring: pointers meet
    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid == '0) |-> (r_rd_ptr == r_wr_ptr))
        else $error("empty ring with read and write pointers apart");

    // Used count never exceeds the buffer size
    a_prev_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_prev_used <= BUF_LEN)
        else $error("previous used count out of range");

    // Every accepted transaction produces a result next cycle
    a_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> r_out_valid)
        else $error("accepted transaction without result");

    // A nonzero segment length only comes with the accepted flag
    a_pop_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_data.segment_length != '0)) |-> r_out_data.accepted)
        else $error("segment returned without accepted flag");

endmodule

[sim/tb_dma_rx_segment_queue.sv]
`timescale 1ns / 100ps
// Self-checking testbench for dma_rx_segment_queue: directed and random push/pop traffic.
// Depends on dsq_pkg and the dma_rx_segment_queue RTL; drives both channels with random idling.
module tb_dma_rx_segment_queue;
    import dsq_pkg::*;

    localparam int IDLE_LIMIT  = 2000;  // watchdog: cycles with no transaction on either side
    localparam int RANDOM_TXNS = 1650;

    typedef struct {
        t_in txn;
        bit  wait_drain;   // hold this transaction until every result has come back
    } t_pending;

    logic  i_clk       = 1'b0;
    logic  i_rst_n     = 1'b0;
    logic  i_in_valid  = 1'b0;
    t_in   i_in_data   = '0;
    logic  i_out_stall = 1'b0;
    logic  o_in_stall;
    logic  o_out_valid;
    t_out  o_out_data;

    t_pending stim_q[$];
    t_out     seg_expect_q[$];

    // Shadow copy of the descriptor ring
    logic [START_W-1:0] ring_start [RING_DEPTH];
    logic [LEN_W-1:0]   ring_len   [RING_DEPTH];
    bit                 ring_valid [RING_DEPTH] = '{default: 1'b0};
    logic [PTR_W-1:0]   rd_ptr    = '0;
    logic [PTR_W-1:0]   wr_ptr    = '0;
    logic [LEN_W-1:0]   last_used = '0;

    int  cyc          = 0;
    int  idle_cycles  = 0;
    int  mismatches   = 0;
    int  n_stored     = 0;
    int  n_refused    = 0;
    int  n_popped     = 0;
    int  n_empty_pops = 0;
    bit  in_taken     = 1'b0;

    wire in_fire  = i_in_valid && !o_in_stall;
    wire out_fire = o_out_valid && !i_out_stall;
    // Both sides run without idling inside this window
    wire quiet    = (cyc >= 600) && (cyc < 1100);

    dma_rx_segment_queue dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data)
    );

    always #4 i_clk = ~i_clk;

    function automatic logic [PTR_W-1:0] ring_bump(logic [PTR_W-1:0] p);
        return (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    // Applies one transaction to the shadow ring and returns the result it should give
    function automatic t_out segment_ring_update(t_in txn);
        t_out             res;
        logic [LEN_W-1:0] remain;
        logic [LEN_W-1:0] used_now;
        res = '0;
        if (txn.command == CMD_PUSH) begin
            // remaining counts past the buffer size clamp to "nothing used"
            remain = (txn.remain_count > LEN_W'(BUFFER_BYTES)) ? LEN_W'(BUFFER_BYTES)
                                                                : txn.remain_count;
            used_now = LEN_W'(BUFFER_BYTES) - remain;
            if (used_now != last_used) begin
                // overwrite of the oldest descriptor drags the read side along
                if (ring_valid[wr_ptr])
                    rd_ptr = ring_bump(rd_ptr);
                ring_start[wr_ptr] = START_W'(last_used % BUFFER_BYTES);
                ring_len[wr_ptr]   = (last_used < used_now) ? used_now - last_used
                                   : LEN_W'(BUFFER_BYTES) - last_used + used_now;
                ring_valid[wr_ptr] = 1'b1;
                last_used          = used_now;
                wr_ptr             = ring_bump(wr_ptr);
                res.accepted       = 1'b1;
                n_stored++;
            end else begin
                n_refused++;
            end
        end else if (ring_valid[rd_ptr]) begin
            res.accepted       = 1'b1;
            res.segment_start  = ring_start[rd_ptr];
            res.segment_length = ring_len[rd_ptr];
            ring_valid[rd_ptr] = 1'b0;
            rd_ptr             = ring_bump(rd_ptr);
            n_popped++;
        end else begin
            n_empty_pops++;
        end
        res.queue_empty = !ring_valid[rd_ptr];
        return res;
    endfunction

    task automatic queue_txn(logic cmd, int remain, bit drain);
        t_pending p;
        p.txn.command      = cmd;
        p.txn.remain_count = LEN_W'(remain);
        p.wait_drain       = drain;
        stim_q.push_back(p);
    endtask

    task automatic report_mismatch(string what, t_out want, t_out got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("[%0t] %s: expected acc=%0d start=%0d len=%0d empty=%0d",
                     $realtime, what, want.accepted, want.segment_start,
                     want.segment_length, want.queue_empty);
            $display("    got acc=%0d start=%0d len=%0d empty=%0d",
                     got.accepted, got.segment_start, got.segment_length,
                     got.queue_empty);
        end
    endtask

    // Sender and receiver, both updated on the falling edge
    always @(negedge i_clk) begin : drive_proc
        bit idle_now;
        idle_now = !quiet && ($urandom_range(0, 99) < 25);
        if (i_rst_n && (!i_in_valid || in_taken)) begin
            if (stim_q.size() != 0 && !idle_now &&
                !(stim_q[0].wait_drain && seg_expect_q.size() != 0)) begin
                i_in_data  <= stim_q[0].txn;
                i_in_valid <= 1'b1;
                void'(stim_q.pop_front());
            end else begin
                i_in_valid <= 1'b0;
            end
        end
        i_out_stall <= i_rst_n && !quiet && ($urandom_range(0, 99) < 25);
    end

    // Result check first, then prediction for the transaction taken at this edge
    always @(posedge i_clk) begin : check_proc
        t_out want;
        t_out got;
        cyc      <= cyc + 1;
        in_taken <= i_rst_n && in_fire;
        if (i_rst_n && out_fire) begin
            got = o_out_data;
            if (seg_expect_q.size() == 0) begin
                report_mismatch("unexpected result", '0, got);
            end else begin
                want = seg_expect_q.pop_front();
                if (got !== want)
                    report_mismatch("wrong result", want, got);
            end
        end
        if (i_rst_n && in_fire)
            seg_expect_q.push_back(segment_ring_update(i_in_data));
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || in_fire || out_fire) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Watchdog: no transaction for %0d cycles", IDLE_LIMIT);
            $display("Mismatches found");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int used_pos;
        int dma_remain;
        int step;
        int pick;
        int pop_pct;

        // Directed part
        queue_txn(CMD_POP, 0, 0);               // pop from an empty ring
        queue_txn(CMD_PUSH, BUFFER_BYTES, 0);   // nothing new since reset
        queue_txn(CMD_PUSH, 2047, 0);           // clamped, still nothing new
        queue_txn(CMD_PUSH, 1000, 0);
        queue_txn(CMD_POP, 2047, 0);
        queue_txn(CMD_PUSH, 0, 0);              // buffer completely used
        queue_txn(CMD_PUSH, BUFFER_BYTES, 0);   // previous used == buffer size, start at 0
        queue_txn(CMD_PUSH, 1500, 0);           // clamped to the same used count: refused
        queue_txn(CMD_PUSH, 100, 0);
        queue_txn(CMD_PUSH, 1000, 0);           // wraps past the end of the buffer
        for (int k = 0; k < 8; k++)             // overfill the ring
            queue_txn(CMD_PUSH, 900 - 100 * k, 0);
        queue_txn(CMD_POP, 1023, 1);            // sender holds until all results are back
        for (int k = 0; k < 5; k++)
            queue_txn(CMD_POP, 0, 0);

        // Random part: mostly a DMA counter that walks around the buffer
        used_pos   = BUFFER_BYTES - 200;
        dma_remain = 200;
        pop_pct    = 40;
        for (int n = 0; n < RANDOM_TXNS; n++) begin
            if (n % 50 == 0) begin
                case ($urandom_range(0, 2))
                    0: pop_pct = 10;
                    1: pop_pct = 45;
                    default: pop_pct = 75;
                endcase
            end
            if ($urandom_range(0, 99) < pop_pct) begin
                queue_txn(CMD_POP, $urandom_range(0, 2047), n % 400 == 399);
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 72) begin
                    step = ($urandom_range(0, 9) == 0) ? $urandom_range(1, BUFFER_BYTES - 1)
                                                       : $urandom_range(1, 64);
                    used_pos   = (used_pos + step) % BUFFER_BYTES;
                    dma_remain = BUFFER_BYTES - used_pos;
                end else if (pick < 90) begin
                    if (pick >= 82)
                        dma_remain = $urandom_range(BUFFER_BYTES + 1, 2047);
                    // else: repeat the last count, nothing new
                end else if (pick < 94) begin
                    dma_remain = 0;
                end else begin
                    dma_remain = $urandom_range(0, 2047);
                end
                queue_txn(CMD_PUSH, dma_remain, n % 400 == 399);
            end
        end

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (stim_q.size() != 0 || i_in_valid)
            @(negedge i_clk);
        while (seg_expect_q.size() != 0)
            @(negedge i_clk);
        repeat (8) @(negedge i_clk);

        $display("Run covered %0d segments stored, %0d pushes refused,", n_stored, n_refused);
        $display("%0d segments popped and %0d pops from an empty ring.", n_popped, n_empty_pops);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("%0d bad results", mismatches);
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/dsq_pkg.sv
rtl/dma_rx_segment_queue.sv
sim/tb_dma_rx_segment_queue.sv
